[hdl/frame_timestamp_regularizer_top_defines.svh]
// Assertion macros shared by the frame timestamp regularizer modules.
`ifndef FRAME_TIMESTAMP_REGULARIZER_TOP_DEFINES_SVH
`define FRAME_TIMESTAMP_REGULARIZER_TOP_DEFINES_SVH

`ifndef SYNTHESIS
`define FTR_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");
`define FTR_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");
`else
`define FTR_ASSERT_NOW(label, ante, cons)
`define FTR_ASSERT_NEXT(label, ante, cons)
`endif

`endif

[hdl/ftr_pkg.sv]
// Types and constants of the frame timestamp regularizer.
`default_nettype none

package ftr_pkg;

    localparam int HANDLE_W       = 16;
    localparam int PTS_W          = 47;
    localparam int FRAC_W         = 16;
    localparam int TIME_W         = 64;
    localparam int INTERVAL_W     = 32;
    localparam int MAX_DUPLICATES = 63;
    localparam int DUP_W          = $clog2(MAX_DUPLICATES + 1);

    localparam logic [INTERVAL_W-1:0] INTERVAL_RESET = INTERVAL_W'(65536);

    typedef enum logic [1:0] {
        ACT_FIRST   = 2'd0,
        ACT_QUEUED  = 2'd1,
        ACT_DUP     = 2'd2,
        ACT_DROPPED = 2'd3
    } action_t;

    typedef enum logic {
        ST_IDLE,
        ST_DECIDE
    } state_t;

    typedef enum logic [2:0] {
        CMD_NONE,
        CMD_ACCEPT,
        CMD_FIRST,
        CMD_DUP,
        CMD_CAPPED,
        CMD_FINAL
    } cmd_t;

    typedef struct packed {
        logic have_tail;
        logic too_late;
        logic at_limit;
        logic out_free;
    } status_t;

endpackage

`default_nettype wire

[hdl/ftr_in_if.sv]
// Frame input channel: valid/ready handshake with handle and timestamp.
`default_nettype none

interface ftr_in_if;

    logic                         valid;
    logic                         ready;
    logic [ftr_pkg::HANDLE_W-1:0] frame_handle;
    logic [ftr_pkg::PTS_W-1:0]    frame_pts;

    modport source (output valid, output frame_handle, output frame_pts, input ready);
    modport sink (input valid, input frame_handle, input frame_pts, output ready);

endinterface

`default_nettype wire

[hdl/ftr_out_if.sv]
// Result output channel: valid/ready handshake with one result per transfer.
`default_nettype none

interface ftr_out_if;

    logic                         valid;
    logic                         ready;
    logic [1:0]                   action;
    logic [ftr_pkg::HANDLE_W-1:0] out_frame_handle;
    logic [ftr_pkg::PTS_W-1:0]    out_pts;
    logic                         gap_capped;
    logic                         last;

    modport source (
        output valid, output action, output out_frame_handle, output out_pts,
        output gap_capped, output last, input ready
    );
    modport sink (
        input valid, input action, input out_frame_handle, input out_pts,
        input gap_capped, input last, output ready
    );

endinterface

`default_nettype wire

[hdl/frame_timestamp_regularizer_top.sv]
// Top level of the frame timestamp regularizer: controller plus datapath.
//
//  Channel     Role    Carries
//  frame_in    sink    frame_handle, frame_pts
//  result_out  source  action, out_frame_handle, out_pts, gap_capped, last
//  cfg         write   frame_interval (Q16.16), no read-back
//
// A frame is taken in an accept step and then gives one result per cycle in the
// decide state, which compares the frame against the registered next and
// next-but-one slot times and issues at most one result.
// A full result register that is not being taken holds the decide state.
// The next frame transfer is taken while the last result still waits.
// Reset clears the tail state and loads an interval of one tick.
`default_nettype none

module frame_timestamp_regularizer_top (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic                           cfg_we,
    input  wire logic [ftr_pkg::INTERVAL_W-1:0] cfg_wdata,
    ftr_in_if.sink                              frame_in,
    ftr_out_if.source                           result_out
);

    ftr_pkg::cmd_t    cmd;
    ftr_pkg::status_t status;
    logic             in_ready;

    assign frame_in.ready = in_ready;

    ftr_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (frame_in.valid),
        .in_ready (in_ready),
        .status   (status),
        .cmd      (cmd)
    );

    ftr_datapath u_datapath (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_we       (cfg_we),
        .cfg_wdata    (cfg_wdata),
        .frame_handle (frame_in.frame_handle),
        .frame_pts    (frame_in.frame_pts),
        .cmd          (cmd),
        .status       (status),
        .result_out   (result_out)
    );

endmodule

`default_nettype wire

[hdl/ftr_ctrl.sv]
// Controller state machine that sequences accept, first, duplicate, capped and final steps.
`default_nettype none

`include "frame_timestamp_regularizer_top_defines.svh"

module ftr_ctrl (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             in_valid,
    output logic                  in_ready,
    input  wire ftr_pkg::status_t status,
    output ftr_pkg::cmd_t         cmd
);

    ftr_pkg::state_t state_reg;
    ftr_pkg::state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ftr_pkg::ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cmd        = ftr_pkg::CMD_NONE;
        in_ready   = 1'b0;
        case (state_reg)
            ftr_pkg::ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd        = ftr_pkg::CMD_ACCEPT;
                    state_next = ftr_pkg::ST_DECIDE;
                end
            end
            ftr_pkg::ST_DECIDE:
            begin
                if (status.out_free)
                begin
                    if (!status.have_tail)
                    begin
                        cmd        = ftr_pkg::CMD_FIRST;
                        state_next = ftr_pkg::ST_IDLE;
                    end
                    else if (status.too_late && status.at_limit)
                    begin
                        cmd        = ftr_pkg::CMD_CAPPED;
                        state_next = ftr_pkg::ST_IDLE;
                    end
                    else if (status.too_late)
                    begin
                        cmd = ftr_pkg::CMD_DUP;
                    end
                    else
                    begin
                        cmd        = ftr_pkg::CMD_FINAL;
                        state_next = ftr_pkg::ST_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = ftr_pkg::ST_IDLE;
            end
        endcase
    end

    `FTR_ASSERT_NOW(a_emit_needs_room,
        cmd == ftr_pkg::CMD_FIRST || cmd == ftr_pkg::CMD_DUP ||
        cmd == ftr_pkg::CMD_CAPPED || cmd == ftr_pkg::CMD_FINAL,
        status.out_free)
    `FTR_ASSERT_NEXT(a_dup_keeps_deciding, cmd == ftr_pkg::CMD_DUP,
        state_reg == ftr_pkg::ST_DECIDE && !in_ready)

endmodule

`default_nettype wire

[hdl/ftr_datapath.sv]
// Datapath: tail state, slot arithmetic, compares and the result register.
`default_nettype none

`include "frame_timestamp_regularizer_top_defines.svh"

module ftr_datapath (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic                           cfg_we,
    input  wire logic [ftr_pkg::INTERVAL_W-1:0] cfg_wdata,
    input  wire logic [ftr_pkg::HANDLE_W-1:0]   frame_handle,
    input  wire logic [ftr_pkg::PTS_W-1:0]      frame_pts,
    input  wire ftr_pkg::cmd_t                  cmd,
    output ftr_pkg::status_t                    status,
    ftr_out_if.source                           result_out
);

    localparam int TW = ftr_pkg::TIME_W;
    localparam int PW = ftr_pkg::PTS_W;
    localparam int FW = ftr_pkg::FRAC_W;

    logic [ftr_pkg::INTERVAL_W-1:0] interval_reg;
    logic                           have_tail_reg;
    logic [TW-1:0]                  tail_time_reg;
    logic [ftr_pkg::HANDLE_W-1:0]   tail_handle_reg;
    logic [ftr_pkg::HANDLE_W-1:0]   in_handle_reg;
    logic [TW-1:0]                  pts_q_reg;
    logic [TW-1:0]                  next_reg;
    logic [TW-1:0]                  far_reg;
    logic [ftr_pkg::DUP_W-1:0]      dup_count_reg;

    logic                           out_valid_reg;
    logic                           out_valid_next;
    ftr_pkg::action_t               out_action_reg;
    ftr_pkg::action_t               out_action_next;
    logic [ftr_pkg::HANDLE_W-1:0]   out_handle_reg;
    logic [ftr_pkg::HANDLE_W-1:0]   out_handle_next;
    logic [PW-1:0]                  out_pts_reg;
    logic [PW-1:0]                  out_pts_next;
    logic                           out_capped_reg;
    logic                           out_capped_next;
    logic                           out_last_reg;
    logic                           out_last_next;

    logic                           emit;
    logic [TW-1:0]                  half_sum;
    logic                           late_enough;

    assign half_sum    = pts_q_reg + TW'(interval_reg >> 1);
    assign late_enough = interval_reg[0] ? (half_sum >= next_reg) : (half_sum > next_reg);

    assign status.have_tail = have_tail_reg;
    assign status.too_late  = pts_q_reg > far_reg;
    assign status.at_limit  = dup_count_reg == ftr_pkg::DUP_W'(ftr_pkg::MAX_DUPLICATES);
    assign status.out_free  = !out_valid_reg || result_out.ready;

    always_comb
    begin
        emit            = 1'b1;
        out_action_next = ftr_pkg::ACT_DROPPED;
        out_handle_next = in_handle_reg;
        out_pts_next    = '0;
        out_capped_next = 1'b0;
        out_last_next   = 1'b1;
        case (cmd)
            ftr_pkg::CMD_FIRST:
            begin
                out_action_next = ftr_pkg::ACT_FIRST;
                out_pts_next    = pts_q_reg[FW+PW-1:FW];
            end
            ftr_pkg::CMD_DUP:
            begin
                out_action_next = ftr_pkg::ACT_DUP;
                out_handle_next = tail_handle_reg;
                out_pts_next    = next_reg[FW+PW-1:FW];
                out_last_next   = 1'b0;
            end
            ftr_pkg::CMD_CAPPED:
            begin
                out_action_next = ftr_pkg::ACT_QUEUED;
                out_pts_next    = next_reg[FW+PW-1:FW];
                out_capped_next = 1'b1;
            end
            ftr_pkg::CMD_FINAL:
            begin
                if (late_enough)
                begin
                    out_action_next = ftr_pkg::ACT_QUEUED;
                    out_pts_next    = next_reg[FW+PW-1:FW];
                end
            end
            default:
            begin
                emit = 1'b0;
            end
        endcase
    end

    always_comb
    begin
        if (emit)
        begin
            out_valid_next = 1'b1;
        end
        else if (result_out.ready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            interval_reg    <= ftr_pkg::INTERVAL_RESET;
            have_tail_reg   <= 1'b0;
            tail_time_reg   <= '0;
            tail_handle_reg <= '0;
            dup_count_reg   <= '0;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
            if (cfg_we)
            begin
                interval_reg <= cfg_wdata;
            end
            case (cmd)
                ftr_pkg::CMD_ACCEPT:
                begin
                    dup_count_reg <= '0;
                end
                ftr_pkg::CMD_FIRST:
                begin
                    have_tail_reg   <= 1'b1;
                    tail_time_reg   <= pts_q_reg;
                    tail_handle_reg <= in_handle_reg;
                end
                ftr_pkg::CMD_DUP:
                begin
                    tail_time_reg <= next_reg;
                    dup_count_reg <= dup_count_reg + 1'b1;
                end
                ftr_pkg::CMD_CAPPED:
                begin
                    tail_time_reg   <= next_reg;
                    tail_handle_reg <= in_handle_reg;
                end
                ftr_pkg::CMD_FINAL:
                begin
                    if (late_enough)
                    begin
                        tail_time_reg   <= next_reg;
                        tail_handle_reg <= in_handle_reg;
                    end
                end
                default:
                begin
                end
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd == ftr_pkg::CMD_ACCEPT)
        begin
            in_handle_reg <= frame_handle;
            pts_q_reg     <= {1'b0, frame_pts, {FW{1'b0}}};
            next_reg      <= tail_time_reg + TW'(interval_reg);
            far_reg       <= tail_time_reg + TW'({interval_reg, 1'b0});
        end
        else if (cmd == ftr_pkg::CMD_DUP)
        begin
            next_reg <= far_reg;
            far_reg  <= far_reg + TW'(interval_reg);
        end
        if (emit)
        begin
            out_action_reg <= out_action_next;
            out_handle_reg <= out_handle_next;
            out_pts_reg    <= out_pts_next;
            out_capped_reg <= out_capped_next;
            out_last_reg   <= out_last_next;
        end
    end

    assign result_out.valid            = out_valid_reg;
    assign result_out.action           = out_action_reg;
    assign result_out.out_frame_handle = out_handle_reg;
    assign result_out.out_pts          = out_pts_reg;
    assign result_out.gap_capped       = out_capped_reg;
    assign result_out.last             = out_last_reg;

    `FTR_ASSERT_NEXT(a_dup_counts, cmd == ftr_pkg::CMD_DUP,
        dup_count_reg == $past(dup_count_reg) + 1'b1 && tail_time_reg == $past(next_reg))
    `FTR_ASSERT_NEXT(a_tail_stays, have_tail_reg, have_tail_reg)

endmodule

`default_nettype wire

[tb/frame_timestamp_regularizer_checker.sv]
// Checker for the frame timestamp regularizer: predicts slot results per frame and compares them.
module frame_timestamp_regularizer_checker
    import ftr_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_we,
    input  logic [INTERVAL_W-1:0] cfg_wdata,
    ftr_in_if                     frame_mon,
    ftr_out_if                    result_mon,
    output int                    fail_count,
    output int                    pending,
    output logic [TIME_W-1:0]     tail_time,
    output int                    results_seen,
    output int                    dups_seen,
    output int                    capped_seen,
    output int                    drops_seen
);

    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        action_t               action;
        logic [HANDLE_W-1:0]   handle;
        logic [PTS_W-1:0]      pts;
        logic                  capped;
        logic                  last;
    } slot_result_t;

    slot_result_t          slot_results[$];
    bit                    have_tail;
    logic [HANDLE_W-1:0]   tail_handle;
    logic [INTERVAL_W-1:0] frame_interval;

    function automatic void queue_result(action_t act, logic [HANDLE_W-1:0] h,
                                         logic [PTS_W-1:0] p, logic capped, logic fin);
        slot_results.push_back('{act, h, p, capped, fin});
    endfunction

    function automatic void conform_frame(logic [HANDLE_W-1:0] h, logic [PTS_W-1:0] p);
        logic [TIME_W-1:0] pts_q;
        logic [TIME_W-1:0] span;
        logic [TIME_W-1:0] half;
        logic [TIME_W-1:0] slot;
        int                repeats;
        bit                late_enough;
        pts_q = {1'b0, p, {FRAC_W{1'b0}}};
        span = TIME_W'(frame_interval);
        half = span >> 1;
        repeats = 0;
        if (!have_tail)
        begin
            have_tail = 1'b1;
            tail_time = pts_q;
            tail_handle = h;
            queue_result(ACT_FIRST, h, p, 1'b0, 1'b1);
            return;
        end
        slot = tail_time + span;
        while (pts_q > slot + span)
        begin
            if (repeats >= MAX_DUPLICATES)
            begin
                tail_time = slot;
                tail_handle = h;
                queue_result(ACT_QUEUED, h, slot[62:16], 1'b1, 1'b1);
                return;
            end
            queue_result(ACT_DUP, tail_handle, slot[62:16], 1'b0, 1'b0);
            repeats++;
            tail_time = slot;
            slot = tail_time + span;
        end
        // An odd interval has a half LSB, so the comparison includes equality.
        if (frame_interval[0])
            late_enough = (pts_q + half) >= slot;
        else
            late_enough = (pts_q + half) > slot;
        if (late_enough)
        begin
            tail_time = slot;
            tail_handle = h;
            queue_result(ACT_QUEUED, h, slot[62:16], 1'b0, 1'b1);
        end
        else
            queue_result(ACT_DROPPED, h, '0, 1'b0, 1'b1);
    endfunction

    function automatic void check_field(string name, logic [63:0] want, logic [63:0] got);
        if (got !== want)
        begin
            $error("%s: expected %0d, got %0d", name, want, got);
            fail_count++;
        end
    endfunction

    function automatic void check_result();
        slot_result_t want;
        if (slot_results.size() == 0)
        begin
            $error("result transfer with nothing outstanding: action %0d handle %0h pts %0d",
                   result_mon.action, result_mon.out_frame_handle, result_mon.out_pts);
            fail_count++;
            return;
        end
        want = slot_results.pop_front();
        check_field("action", 64'(want.action), 64'(result_mon.action));
        check_field("out_frame_handle", 64'(want.handle), 64'(result_mon.out_frame_handle));
        check_field("out_pts", 64'(want.pts), 64'(result_mon.out_pts));
        check_field("gap_capped", 64'(want.capped), 64'(result_mon.gap_capped));
        check_field("last", 64'(want.last), 64'(result_mon.last));
        results_seen++;
        if (want.action == ACT_DUP)
            dups_seen++;
        if (want.action == ACT_DROPPED)
            drops_seen++;
        if (want.capped)
            capped_seen++;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            have_tail = 1'b0;
            tail_time = '0;
            tail_handle = '0;
            frame_interval = INTERVAL_RESET;
            slot_results.delete();
            pending = 0;
        end
        else
        begin
            if (result_mon.valid && result_mon.ready)
                check_result();
            if (frame_mon.valid && frame_mon.ready)
                conform_frame(frame_mon.frame_handle, frame_mon.frame_pts);
            if (cfg_we)
                frame_interval = cfg_wdata;
            pending = slot_results.size();
        end
    end

endmodule

[tb/frame_timestamp_regularizer_top_tb.sv]
// Testbench top for the frame timestamp regularizer: clock, reset, stimulus and verdict.
module frame_timestamp_regularizer_top_tb;

    timeunit 1ns;
    timeprecision 1ps;

    import ftr_pkg::*;

    localparam logic [63:0] PTS_MAX = (64'd1 << PTS_W) - 64'd1;
    localparam logic [63:0] BASE_PTS = PTS_MAX - 64'd67108864;
    localparam int CYCLE_LIMIT = 500000;

    logic                  clk;
    logic                  rst_n;
    logic                  cfg_we;
    logic [INTERVAL_W-1:0] cfg_wdata;

    ftr_in_if  frame_in ();
    ftr_out_if result_out ();

    int                    fail_count;
    int                    pending;
    logic [TIME_W-1:0]     tail_q;
    int                    results_seen;
    int                    dups_seen;
    int                    capped_seen;
    int                    drops_seen;
    int                    cycle_count;
    int                    frames_sent;
    int                    settings_used;
    bit                    steady;
    logic [INTERVAL_W-1:0] cur_iv;

    frame_timestamp_regularizer_top u_top (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_we     (cfg_we),
        .cfg_wdata  (cfg_wdata),
        .frame_in   (frame_in),
        .result_out (result_out)
    );

    frame_timestamp_regularizer_checker u_checker (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_we       (cfg_we),
        .cfg_wdata    (cfg_wdata),
        .frame_mon    (frame_in),
        .result_mon   (result_out),
        .fail_count   (fail_count),
        .pending      (pending),
        .tail_time    (tail_q),
        .results_seen (results_seen),
        .dups_seen    (dups_seen),
        .capped_seen  (capped_seen),
        .drops_seen   (drops_seen)
    );

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("[frame_timestamp_regularizer_top] ERROR");
            $finish;
        end
    end

    initial
    begin
        result_out.ready = 1'b0;
        @(posedge rst_n);
        @(negedge clk);
        forever
        begin
            int stall;
            stall = steady ? 0 : $urandom_range(0, 6);
            if (stall > 0)
            begin
                result_out.ready <= 1'b0;
                repeat (stall) @(negedge clk);
            end
            result_out.ready <= 1'b1;
            do @(posedge clk); while (!result_out.valid);
            @(negedge clk);
        end
    end

    function automatic logic [PTS_W-1:0] past_base(int unsigned ticks);
        return PTS_W'(BASE_PTS + ticks);
    endfunction

    // Mostly frames near the next slot, with early frames, gaps, long gaps and noise mixed in.
    function automatic logic [PTS_W-1:0] draw_pts(logic [TIME_W-1:0] tail,
                                                  logic [INTERVAL_W-1:0] iv);
        logic [TIME_W-1:0] span;
        logic [TIME_W-1:0] q;
        int                kind;
        span = TIME_W'(iv);
        kind = $urandom_range(0, 99);
        if (kind < 55)
            q = tail + span - (span >> 1) + TIME_W'($urandom_range(0, iv));
        else if (kind < 70)
            q = tail - (TIME_W'($urandom_range(0, 3)) << FRAC_W);
        else if (kind < 90)
            q = tail + span * TIME_W'($urandom_range(2, 8)) + TIME_W'($urandom_range(0, iv));
        else if (kind < 94)
            q = tail + span * TIME_W'($urandom_range(66, 120));
        else
            return PTS_W'({$urandom, $urandom});
        return q[62:16];
    endfunction

    task automatic send_frame(input logic [HANDLE_W-1:0] h, input logic [PTS_W-1:0] p);
        int gap;
        gap = steady ? 0 : $urandom_range(0, 6);
        if (gap > 0)
        begin
            frame_in.valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        frame_in.valid <= 1'b1;
        frame_in.frame_handle <= h;
        frame_in.frame_pts <= p;
        do @(posedge clk); while (!frame_in.ready);
        @(negedge clk);
        frames_sent++;
    endtask

    task automatic write_interval(input logic [INTERVAL_W-1:0] value);
        frame_in.valid <= 1'b0;
        while (pending != 0) @(negedge clk);
        cfg_we <= 1'b1;
        cfg_wdata <= value;
        @(negedge clk);
        cfg_we <= 1'b0;
        cur_iv = value;
        settings_used++;
    endtask

    initial
    begin : stimulus
        logic [INTERVAL_W-1:0] random_ivs [5];
        logic [TIME_W-1:0]     gap_q;
        rst_n = 1'b0;
        cfg_we = 1'b0;
        cfg_wdata = '0;
        frame_in.valid = 1'b0;
        frame_in.frame_handle = '0;
        frame_in.frame_pts = '0;
        steady = 1'b0;
        cur_iv = INTERVAL_RESET;
        settings_used = 1;
        random_ivs = '{32'h0002_8000, 32'h0001_5555, 32'h0BBB_0000, 32'h0000_FFFF, $urandom};
        repeat (12) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // With the reset interval of one tick: first frame, a drop at timestamp zero,
        // exactly two intervals late, one duplicate, a repeated timestamp and a capped gap.
        send_frame(16'h0000, past_base(0));
        send_frame(16'hFFFF, '0);
        send_frame(16'h0001, past_base(1));
        send_frame(16'h0002, past_base(3));
        send_frame(16'h0003, past_base(5));
        send_frame(16'h0004, past_base(4));
        send_frame(16'h0005, past_base(200));

        // The half-interval boundary for an even and an odd interval.
        write_interval(32'h0002_0000);
        send_frame(16'h0006, past_base(69));
        write_interval(32'h0001_FFFF);
        send_frame(16'h0007, past_base(69));

        write_interval(32'h0000_0001);
        send_frame(16'h0008, past_base(100));
        write_interval(32'h0000_0000);
        send_frame(16'h0009, past_base(200));
        send_frame(16'h000A, past_base(69));
        write_interval(32'hFFFF_FFFF);
        send_frame(16'h000B, PTS_W'(PTS_MAX));

        for (int phase = 0; phase < 5; phase++)
        begin
            write_interval(random_ivs[phase]);
            steady = (phase == 2);
            repeat (30) send_frame(HANDLE_W'($urandom), draw_pts(tail_q, cur_iv));
        end
        steady = 1'b0;

        // Walk the tail up to the top of the timestamp range, then make the slot time wrap.
        write_interval(32'hFFFF_FFFF);
        while ((tail_q >> FRAC_W) + 64'd900000 < PTS_MAX)
            send_frame(HANDLE_W'($urandom), PTS_W'(PTS_MAX - 64'd500000));
        if ((tail_q >> FRAC_W) + 64'd40000 < PTS_MAX)
        begin
            write_interval(32'h4000_0000);
            send_frame(HANDLE_W'($urandom), PTS_W'(PTS_MAX - 64'd16384));
            gap_q = {1'b0, PTS_MAX[PTS_W-1:0], {FRAC_W{1'b0}}} - tail_q;
            write_interval(INTERVAL_W'(gap_q + (gap_q >> 1)));
            send_frame(HANDLE_W'($urandom), PTS_W'(PTS_MAX));
        end

        frame_in.valid <= 1'b0;
        while (pending != 0) @(negedge clk);
        repeat (8) @(negedge clk);
        $display("Sent %0d frames under %0d interval settings; checked %0d results.",
                 frames_sent, settings_used, results_seen);
        $display("Seen %0d duplicates, %0d capped snaps and %0d dropped frames.",
                 dups_seen, capped_seen, drops_seen);
        if (fail_count == 0 && pending == 0)
            $display("[frame_timestamp_regularizer_top] OK");
        else
            $display("[frame_timestamp_regularizer_top] ERROR");
        $finish;
    end

endmodule
